// ===== hw/rtl/kle_pkg.sv =====
// Package: shared constants, codes and types for the keyboard line editor.
package kle_pkg;

  localparam int LINE_MAX     = 256;
  localparam int STORE_SPAN   = 256;
  localparam int LINE_CAP_INT = (LINE_MAX < STORE_SPAN) ? LINE_MAX : STORE_SPAN;

  localparam int CAP_W  = 9;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 8;

  localparam logic [CAP_W-1:0] LINE_CAP = CAP_W'(LINE_CAP_INT);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_KEY   = 1'b1;

  localparam logic [BYTE_W-1:0] KEY_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] KEY_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] KEY_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] KEY_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] KEY_SP  = 8'h20;

  typedef enum logic [1:0] {
    JOB_CHAR,
    JOB_EOL,
    JOB_ERASE
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [BYTE_W-1:0]  key;
    logic [POS_W-1:0]   idx;
    logic               done;
    logic [CAP_W-1:0]   count;
  } job_t;

endpackage

// ===== hw/rtl/kle_if.sv =====
// Interfaces: key input channel, result output channel, configuration channel.
interface kle_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [kle_pkg::BYTE_W-1:0] key_byte;

  modport source (output valid, output command, output key_byte, input ready);
  modport sink   (input valid, input command, input key_byte, output ready);
endinterface

interface kle_out_if;
  logic                       valid;
  logic                       ready;
  logic [kle_pkg::BYTE_W-1:0] echo_char;
  logic                       echo_last;
  logic                       store_write;
  logic [kle_pkg::POS_W-1:0]  store_index;
  logic [kle_pkg::BYTE_W-1:0] store_byte;
  logic                       line_done;
  logic [kle_pkg::CAP_W-1:0]  chars_read;

  modport source (output valid, output echo_char, output echo_last, output store_write,
                  output store_index, output store_byte, output line_done,
                  output chars_read, input ready);
  modport sink   (input valid, input echo_char, input echo_last, input store_write,
                  input store_index, input store_byte, input line_done,
                  input chars_read, output ready);
endinterface

interface kle_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kle_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/kle_front.sv =====
// Front end: accept and classify key words, track line state, issue jobs.
module kle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  kle_in_if.sink          in_i,
  kle_cfg_if.sink         cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output kle_pkg::job_t   job_o
);

  logic [kle_pkg::CAP_W-1:0] capacity_q;
  logic                      armed_q, armed_d;
  logic [kle_pkg::CAP_W-1:0] remaining_q, remaining_d;
  logic [kle_pkg::CAP_W-1:0] line_size_q, line_size_d;
  logic [kle_pkg::POS_W-1:0] fill_q, fill_d;
  logic [kle_pkg::CAP_W-1:0] cap;
  logic [kle_pkg::CAP_W-1:0] rem_dec;
  logic                      accept;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign cap         = (capacity_q > kle_pkg::LINE_CAP) ? kle_pkg::LINE_CAP : capacity_q;
  assign rem_dec     = remaining_q - kle_pkg::CAP_W'(1);

  always_comb begin
    armed_d     = armed_q;
    remaining_d = remaining_q;
    line_size_d = line_size_q;
    fill_d      = fill_q;
    push_o      = 1'b0;
    job_o.kind  = kle_pkg::JOB_CHAR;
    job_o.key   = in_i.key_byte;
    job_o.idx   = fill_q;
    job_o.done  = 1'b0;
    job_o.count = '0;
    if (accept) begin
      if (in_i.command == kle_pkg::CMD_BEGIN) begin
        line_size_d = cap;
        remaining_d = cap;
        fill_d      = '0;
        armed_d     = (cap != '0);
      end else if (armed_q && in_i.key_byte != kle_pkg::KEY_NUL) begin
        if (in_i.key_byte == kle_pkg::KEY_BS) begin
          if (remaining_q < line_size_q) begin
            fill_d      = fill_q - kle_pkg::POS_W'(1);
            remaining_d = remaining_q + kle_pkg::CAP_W'(1);
            push_o      = 1'b1;
            job_o.kind  = kle_pkg::JOB_ERASE;
          end
        end else if (in_i.key_byte == kle_pkg::KEY_CR || in_i.key_byte == kle_pkg::KEY_LF) begin
          push_o      = 1'b1;
          job_o.kind  = kle_pkg::JOB_EOL;
          job_o.done  = 1'b1;
          job_o.count = line_size_q - remaining_q;
          armed_d     = 1'b0;
        end else begin
          push_o      = 1'b1;
          job_o.kind  = kle_pkg::JOB_CHAR;
          job_o.done  = (rem_dec == '0);
          job_o.count = line_size_q - rem_dec;
          fill_d      = fill_q + kle_pkg::POS_W'(1);
          remaining_d = rem_dec;
          armed_d     = (rem_dec != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= kle_pkg::CAP_RESET;
      armed_q     <= 1'b0;
      remaining_q <= '0;
      line_size_q <= '0;
      fill_q      <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        capacity_q <= cfg_i.data;
      end
      armed_q     <= armed_d;
      remaining_q <= remaining_d;
      line_size_q <= line_size_d;
      fill_q      <= fill_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) remaining_q <= line_size_q)
    else $error("remaining count exceeds line size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) armed_q |-> remaining_q != '0)
    else $error("armed with a full line");

endmodule

// ===== hw/rtl/kle_queue.sv =====
// Job queue: short FIFO between the front end and the back end.
module kle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kle_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output kle_pkg::job_t job_o,
  output logic          empty_o
);

  kle_pkg::job_t                mem_q [kle_pkg::QUEUE_DEPTH];
  logic [kle_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [kle_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == kle_pkg::QCNT_W'(kle_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  function automatic logic [kle_pkg::QPTR_W-1:0] ptr_next(logic [kle_pkg::QPTR_W-1:0] p);
    logic [kle_pkg::QPTR_W-1:0] r;
    if (p == kle_pkg::QPTR_W'(kle_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + kle_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + kle_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - kle_pkg::QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

// ===== hw/rtl/kle_back.sv =====
// Back end: expand each job into echo/store result words behind an output register.
module kle_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kle_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  kle_out_if.source     out_o
);

  logic [1:0]                 step_q;
  logic                       last_step;
  logic                       load;
  logic                       valid_q;
  logic [kle_pkg::BYTE_W-1:0] echo_d, echo_q;
  logic                       elast_d, elast_q;
  logic                       wr_d, wr_q;
  logic [kle_pkg::POS_W-1:0]  idx_d, idx_q;
  logic [kle_pkg::BYTE_W-1:0] byte_d, byte_q;
  logic                       done_d, done_q;
  logic [kle_pkg::CAP_W-1:0]  cnt_d, cnt_q;

  always_comb begin
    last_step = 1'b1;
    echo_d    = job_i.key;
    elast_d   = 1'b0;
    wr_d      = 1'b0;
    idx_d     = '0;
    byte_d    = '0;
    done_d    = 1'b0;
    cnt_d     = '0;
    case (job_i.kind)
      kle_pkg::JOB_ERASE: begin
        last_step = (step_q == 2'd2);
        echo_d    = (step_q == 2'd1) ? kle_pkg::KEY_SP : kle_pkg::KEY_BS;
        elast_d   = last_step;
      end
      kle_pkg::JOB_EOL: begin
        last_step = (step_q == 2'd1);
        elast_d   = last_step;
        if (last_step) begin
          echo_d = kle_pkg::KEY_LF;
          done_d = 1'b1;
          cnt_d  = job_i.count;
        end else begin
          echo_d = kle_pkg::KEY_CR;
          wr_d   = 1'b1;
          idx_d  = job_i.idx;
          byte_d = kle_pkg::KEY_NUL;
        end
      end
      kle_pkg::JOB_CHAR: begin
        echo_d  = job_i.key;
        elast_d = 1'b1;
        wr_d    = 1'b1;
        idx_d   = job_i.idx;
        byte_d  = job_i.key;
        done_d  = job_i.done;
        cnt_d   = job_i.done ? job_i.count : '0;
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  assign load  = !empty_i && (!valid_q || out_o.ready);
  assign pop_o = load && last_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= last_step ? 2'd0 : step_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      echo_q  <= echo_d;
      elast_q <= elast_d;
      wr_q    <= wr_d;
      idx_q   <= idx_d;
      byte_q  <= byte_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.echo_char   = echo_q;
  assign out_o.echo_last   = elast_q;
  assign out_o.store_write = wr_q;
  assign out_o.store_index = idx_q;
  assign out_o.store_byte  = byte_q;
  assign out_o.line_done   = done_q;
  assign out_o.chars_read  = cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_q != 2'd0) |-> (!empty_i && job_i.kind != kle_pkg::JOB_CHAR))
    else $error("job step in progress without a multi-word job at the head");

endmodule

// ===== hw/rtl/keyboard_line_editor_core.sv =====
// Top level: keyboard line editor with decoupled classify front end and echo back end.
//
//   channel | dir | handshake   | word
//   in_i    | in  | valid/ready | command, key_byte
//   cfg_i   | in  | valid/ready | data = line_capacity
//   out_o   | out | valid/ready | echo_char, echo_last, store_write, store_index,
//           |     |             | store_byte, line_done, chars_read
//
// A key word is taken every cycle while the two-entry job queue has room.
// The back end emits one result word per cycle while out_o is ready: one for a stored
// character, two for end of line, three for an erase.
// Each result word is held in the back end's output register once its job reaches the queue head.
// Reset clears line state and sets line_capacity to 256; cfg_i is always ready.
module keyboard_line_editor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  kle_in_if.sink    in_i,
  kle_cfg_if.sink   cfg_i,
  kle_out_if.source out_o
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  kle_pkg::job_t job_in;
  kle_pkg::job_t job_head;

  kle_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  kle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_head),
    .empty_o (empty)
  );

  kle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/kle_line_checker.sv =====
// Checker for the keyboard line editor: predicts echo words from key and capacity words.
module kle_line_checker
  import kle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kle_in_if    key_mon,
  kle_cfg_if   cap_mon,
  kle_out_if   echo_mon,
  output int   pending_o,
  output int   fail_count_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] echo_char;
    logic              echo_last;
    logic              store_write;
    logic [POS_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              line_done;
    logic [CAP_W-1:0]  chars_read;
  } echo_word_t;

  echo_word_t       echo_due[$];
  echo_word_t       head;
  logic [CAP_W-1:0] cap_reg;
  logic [CAP_W-1:0] line_len;
  logic [CAP_W-1:0] room_left;
  logic [POS_W-1:0] fill_pos;
  logic             line_armed;
  int               errors = 0;

  assign fail_count_o = errors;

  function automatic echo_word_t make_word(input logic [BYTE_W-1:0] echo, input logic last,
                                           input logic wr, input logic [POS_W-1:0] idx,
                                           input logic [BYTE_W-1:0] sbyte, input logic done,
                                           input logic [CAP_W-1:0] count);
    echo_word_t w;
    w.echo_char   = echo;
    w.echo_last   = last;
    w.store_write = wr;
    w.store_index = wr ? idx : '0;
    w.store_byte  = wr ? sbyte : '0;
    w.line_done   = done;
    w.chars_read  = done ? count : '0;
    return w;
  endfunction

  task automatic compare_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      errors++;
    end
  endtask

  task automatic edit_line_key(input logic cmd, input logic [BYTE_W-1:0] key);
    logic [CAP_W-1:0] size;
    if (cmd == CMD_BEGIN) begin
      size       = (cap_reg > LINE_CAP) ? LINE_CAP : cap_reg;
      line_len   = size;
      room_left  = size;
      fill_pos   = '0;
      line_armed = (size != '0);
    end else if (line_armed && key != KEY_NUL) begin
      if (key == KEY_BS) begin
        if (room_left < line_len) begin
          fill_pos  = fill_pos - 1'b1;
          room_left = room_left + 1'b1;
          echo_due.push_back(make_word(KEY_BS, 1'b0, 1'b0, '0, '0, 1'b0, '0));
          echo_due.push_back(make_word(KEY_SP, 1'b0, 1'b0, '0, '0, 1'b0, '0));
          echo_due.push_back(make_word(KEY_BS, 1'b1, 1'b0, '0, '0, 1'b0, '0));
        end
      end else if (key == KEY_CR || key == KEY_LF) begin
        echo_due.push_back(make_word(KEY_CR, 1'b0, 1'b1, fill_pos, KEY_NUL, 1'b0, '0));
        echo_due.push_back(make_word(KEY_LF, 1'b1, 1'b0, '0, '0, 1'b1, line_len - room_left));
        line_armed = 1'b0;
      end else begin
        echo_due.push_back(make_word(key, 1'b1, 1'b1, fill_pos, key, room_left == 1,
                                     line_len - room_left + 1'b1));
        fill_pos  = fill_pos + 1'b1;
        room_left = room_left - 1'b1;
        if (room_left == '0) line_armed = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg    = CAP_RESET;
      line_len   = '0;
      room_left  = '0;
      fill_pos   = '0;
      line_armed = 1'b0;
      echo_due.delete();
      pending_o <= 0;
    end else begin
      if (echo_mon.valid && echo_mon.ready) begin
        if (echo_due.size() == 0) begin
          $error("echo word with nothing expected: echo_char %0h", echo_mon.echo_char);
          errors++;
        end else begin
          head = echo_due.pop_front();
          compare_field("echo_char", head.echo_char, echo_mon.echo_char);
          compare_field("echo_last", head.echo_last, echo_mon.echo_last);
          compare_field("store_write", head.store_write, echo_mon.store_write);
          compare_field("store_index", head.store_index, echo_mon.store_index);
          compare_field("store_byte", head.store_byte, echo_mon.store_byte);
          compare_field("line_done", head.line_done, echo_mon.line_done);
          compare_field("chars_read", head.chars_read, echo_mon.chars_read);
        end
      end
      if (cap_mon.valid && cap_mon.ready) cap_reg = cap_mon.data;
      if (key_mon.valid && key_mon.ready) edit_line_key(key_mon.command, key_mon.key_byte);
      pending_o <= echo_due.size();
    end
  end

endmodule

// ===== tb/keyboard_line_editor_core_test.sv =====
// Testbench top for the keyboard line editor: drives key and capacity words, gives the verdict.
module keyboard_line_editor_core_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 36;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   pending;
  int   fail_count;
  int   quiet_cycles = 0;
  int   items_sent = 0;

  kle_in_if  key_if ();
  kle_cfg_if cap_if ();
  kle_out_if echo_if ();

  keyboard_line_editor_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (key_if),
    .cfg_i  (cap_if),
    .out_o  (echo_if)
  );

  kle_line_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_mon      (key_if),
    .cap_mon      (cap_if),
    .echo_mon     (echo_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    echo_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (key_if.valid && key_if.ready) || (echo_if.valid && echo_if.ready) ||
        (cap_if.valid && cap_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic cmd, input logic [kle_pkg::BYTE_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      key_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_if.valid    <= 1'b1;
    key_if.command  <= cmd;
    key_if.key_byte <= key;
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results;
    key_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [kle_pkg::CAP_W-1:0] value);
    drain_results();
    cap_if.valid <= 1'b1;
    cap_if.data  <= value;
    @(posedge clk_i);
    while (!cap_if.ready) @(posedge clk_i);
    cap_if.valid <= 1'b0;
  endtask

  function automatic logic [kle_pkg::BYTE_W-1:0] plain_key();
    logic [kle_pkg::BYTE_W-1:0] key;
    do begin
      key = kle_pkg::BYTE_W'($urandom_range(1, 255));
    end while (key == kle_pkg::KEY_BS || key == kle_pkg::KEY_CR || key == kle_pkg::KEY_LF);
    return key;
  endfunction

  task automatic type_line(input int size);
    int stored;
    int keys;
    int budget;
    int r;
    bit ended;
    send_word(kle_pkg::CMD_BEGIN, kle_pkg::BYTE_W'($urandom_range(255)));
    stored = 0;
    keys   = 0;
    ended  = (size == 0);
    budget = (size <= 8) ? $urandom_range(1, size + 3) : $urandom_range(1, 12);
    while (!ended && keys < budget) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_BS);
        if (stored > 0) stored--;
      end else if (r < 16) begin
        send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_NUL);
      end else begin
        send_word(kle_pkg::CMD_KEY, plain_key());
        stored++;
        ended = (stored == size);
      end
      keys++;
    end
    if (!ended && $urandom_range(9) != 0) begin
      send_word(kle_pkg::CMD_KEY, $urandom_range(1) ? kle_pkg::KEY_CR : kle_pkg::KEY_LF);
    end
  endtask

  initial begin
    int                         size_now;
    int                         start;
    int                         r;
    logic [kle_pkg::CAP_W-1:0]  cap_val;

    rst_ni          <= 1'b0;
    key_if.valid    <= 1'b0;
    key_if.command  <= kle_pkg::CMD_BEGIN;
    key_if.key_byte <= '0;
    cap_if.valid    <= 1'b0;
    cap_if.data     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(kle_pkg::CMD_KEY, 8'h61);
    send_word(kle_pkg::CMD_BEGIN, 8'hFF);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_NUL);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_BS);
    send_word(kle_pkg::CMD_KEY, 8'hFF);
    send_word(kle_pkg::CMD_KEY, 8'h01);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_BS);
    send_word(kle_pkg::CMD_KEY, 8'h7F);
    send_word(kle_pkg::CMD_KEY, 8'h80);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_CR);
    send_word(kle_pkg::CMD_KEY, 8'h62);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h78);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_LF);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h71);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h72);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_CR);
    write_capacity(9'd1);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h55);
    send_word(kle_pkg::CMD_KEY, 8'hAA);
    write_capacity(9'd0);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h7A);
    write_capacity(9'd511);
    send_word(kle_pkg::CMD_BEGIN, 8'h00);
    send_word(kle_pkg::CMD_KEY, 8'h6B);
    send_word(kle_pkg::CMD_KEY, kle_pkg::KEY_CR);
    size_now = int'(kle_pkg::LINE_CAP);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          r = $urandom_range(99);
          if (r < 60)      cap_val = kle_pkg::CAP_W'($urandom_range(1, 8));
          else if (r < 70) cap_val = 9'd1;
          else if (r < 78) cap_val = 9'd256;
          else if (r < 84) cap_val = 9'd511;
          else if (r < 90) cap_val = 9'd0;
          else             cap_val = kle_pkg::CAP_W'($urandom_range(511));
          write_capacity(cap_val);
          size_now = int'((cap_val > kle_pkg::LINE_CAP) ? kle_pkg::LINE_CAP : cap_val);
        end
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4)) begin
            send_word(1'($urandom_range(1)), kle_pkg::BYTE_W'($urandom_range(255)));
          end
        end else begin
          type_line(size_now);
        end
      end
      drain_results();
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
